// ===== rtl/lrcc_pkg.sv =====
// lrcc_pkg: shared types and constants for the led ring clock controller
// no dependencies; imported by the interfaces, the button debouncer and the top level
`default_nettype none

package lrcc_pkg;

  // ring geometry
  localparam int RING_LEDS = 12;
  localparam int POS_W     = 4;
  localparam logic [POS_W-1:0] RING_LAST = POS_W'(11);

  // configuration register file
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 24;
  localparam int DEB_W       = 16;
  localparam int LONG_W      = 20;
  localparam int FLASH_W     = 16;
  localparam int ADV_W       = 24;

  localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE   = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_LONG_PRESS = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] CFG_FLASH      = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] CFG_ADVANCE    = CFG_INDEX_W'(3);

  localparam logic [DEB_W-1:0]   DEBOUNCE_RESET   = DEB_W'(20);
  localparam logic [LONG_W-1:0]  LONG_PRESS_RESET = LONG_W'(4000);
  localparam logic [FLASH_W-1:0] FLASH_RESET      = FLASH_W'(1000);
  localparam logic [ADV_W-1:0]   ADVANCE_RESET    = ADV_W'(4000);

  // operating modes
  typedef enum logic [1:0] {
    MODE_RUN    = 2'd0,
    MODE_HOUR   = 2'd1,
    MODE_MINUTE = 2'd2,
    MODE_BRIGHT = 2'd3
  } mode_t;

  // button debouncer phases, one-hot
  typedef enum logic [3:0] {
    PH_IDLE        = 4'b0001,
    PH_DEB_PRESS   = 4'b0010,
    PH_PRESSED     = 4'b0100,
    PH_DEB_RELEASE = 4'b1000
  } button_phase_t;

  // press events raised by the debouncer for the current tick
  typedef struct packed {
    logic short_press;
    logic long_press;
  } btn_event_t;

endpackage

`default_nettype wire

// ===== rtl/lrcc_if.sv =====
// lrcc_if: valid/ready channel interfaces for ticks, results and config writes
// depends on lrcc_pkg for field widths
`default_nettype none

interface lrcc_tick_if import lrcc_pkg::*; ();
  logic valid;
  logic ready;
  logic button_pressed;

  modport source (output valid, output button_pressed, input ready);
  modport sink   (input valid, input button_pressed, output ready);
endinterface

interface lrcc_result_if import lrcc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [RING_LEDS-1:0] outer_leds;
  logic [RING_LEDS-1:0] inner_leds;
  logic [1:0]           mode;
  logic [POS_W-1:0]     hour_position;
  logic [POS_W-1:0]     minute_position;

  modport source (output valid, output outer_leds, output inner_leds, output mode,
                  output hour_position, output minute_position, input ready);
  modport sink   (input valid, input outer_leds, input inner_leds, input mode,
                  input hour_position, input minute_position, output ready);
endinterface

interface lrcc_cfg_if import lrcc_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] reg_index;
  logic [CFG_DATA_W-1:0]  wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

// ===== rtl/lrcc_button.sv =====
// lrcc_button: four-phase button debouncer with short and long press detection
// depends on lrcc_pkg (phase enum, event struct, counter widths)
`default_nettype none

module lrcc_button import lrcc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              tick,
  input  wire logic              pressed,
  input  wire logic [DEB_W-1:0]  debounce_ticks,
  input  wire logic [LONG_W-1:0] long_press_ticks,
  output btn_event_t             events
);

  button_phase_t     button_phase, button_phase_next;
  logic [DEB_W-1:0]  debounce_count, debounce_count_next;
  logic [LONG_W-1:0] press_count, press_count_next;
  logic              long_sent, long_sent_next;

  logic [DEB_W-1:0]  deb_bumped;
  logic [LONG_W-1:0] press_bumped;

  // saturating counters
  assign deb_bumped   = (debounce_count == {DEB_W{1'b1}}) ? debounce_count
                                                            : debounce_count + DEB_W'(1);
  assign press_bumped = (press_count < long_press_ticks) ? press_count + LONG_W'(1)
                                                         : press_count;

  // phase transitions and events
  always_comb begin
    button_phase_next   = button_phase;
    debounce_count_next = debounce_count;
    press_count_next    = press_count;
    long_sent_next      = long_sent;
    events              = '0;
    unique case (button_phase)
      PH_IDLE: begin
        if (pressed) begin
          button_phase_next   = PH_DEB_PRESS;
          debounce_count_next = DEB_W'(1);
        end
      end
      PH_DEB_PRESS: begin
        if (pressed) begin
          debounce_count_next = deb_bumped;
          if (deb_bumped >= debounce_ticks) begin
            button_phase_next = PH_PRESSED;
            press_count_next  = '0;
            long_sent_next    = 1'b0;
          end
        end else begin
          button_phase_next   = PH_IDLE;
          debounce_count_next = '0;
        end
      end
      PH_PRESSED: begin
        if (pressed) begin
          press_count_next = press_bumped;
          if (!long_sent && press_bumped >= long_press_ticks) begin
            events.long_press = 1'b1;
            long_sent_next    = 1'b1;
          end
        end else begin
          button_phase_next   = PH_DEB_RELEASE;
          debounce_count_next = DEB_W'(1);
        end
      end
      PH_DEB_RELEASE: begin
        if (!pressed) begin
          debounce_count_next = deb_bumped;
          if (deb_bumped >= debounce_ticks) begin
            events.short_press  = !long_sent;
            button_phase_next   = PH_IDLE;
            debounce_count_next = '0;
          end
        end else begin
          button_phase_next = PH_PRESSED;
          press_count_next  = '0;
          long_sent_next    = 1'b0;
        end
      end
      default: begin
        button_phase_next   = PH_IDLE;
        debounce_count_next = '0;
      end
    endcase
    if (!tick) begin
      events = '0;
    end
  end

  // state registers, updated once per accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      button_phase   <= PH_IDLE;
      debounce_count <= '0;
      press_count    <= '0;
      long_sent      <= 1'b0;
    end else if (tick) begin
      button_phase   <= button_phase_next;
      debounce_count <= debounce_count_next;
      press_count    <= press_count_next;
      long_sent      <= long_sent_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/led_ring_clock_controller_unit.sv =====
// led_ring_clock_controller_unit: top level of the led ring clock controller
// depends on lrcc_pkg, the channel interfaces in lrcc_if and lrcc_button
//
// Usage:
//   tick    - one request per wakeup tick, carrying the raw button level
//   result  - one request per tick: both ring masks (one-hot or blank), the
//             mode and the hour and minute positions the masks were drawn from
//   cfg     - register writes (debounce, long press, flash and advance
//             thresholds), always ready; write only while the block is idle
// A result is registered and appears in the cycle after its tick is accepted.
// Throughput: one tick per cycle unless stalled; every update is a compare, an
//   increment or a small mux on state registers, finished in the cycle of acceptance.
// A single output register holds the result; tick.ready stays high while
//   that register is empty or being taken, so a stalled receiver holds off
//   further ticks only once a result is waiting.
// Reset (synchronous, rst high): thresholds return to 20, 4000, 1000 and
//   4000, mode to normal, positions to twelve o'clock, full brightness,
//   and the result register empties.
`default_nettype none

module led_ring_clock_controller_unit import lrcc_pkg::*; #(
  parameter int BRIGHTNESS_LEVELS = 8
) (
  input  wire logic     clk,
  input  wire logic     rst,
  lrcc_tick_if.sink     tick,
  lrcc_result_if.source result,
  lrcc_cfg_if.sink      cfg
);

  localparam int BW = (BRIGHTNESS_LEVELS > 1) ? $clog2(BRIGHTNESS_LEVELS) : 1;
  localparam logic [BW:0]   LEVELS_EXT  = (BW+1)'(BRIGHTNESS_LEVELS);
  localparam logic [BW-1:0] BRIGHT_TOP  = BW'(BRIGHTNESS_LEVELS - 1);

  // configuration registers
  logic [DEB_W-1:0]   debounce_ticks;
  logic [LONG_W-1:0]  long_press_ticks;
  logic [FLASH_W-1:0] blink_ticks;
  logic [ADV_W-1:0]   ticks_per_advance;

  // clock state
  mode_t              mode_reg, mode_next;
  logic [FLASH_W-1:0] flash_count, flash_count_next;
  logic               flash_visible, flash_visible_next;
  logic [BW-1:0]      brightness, brightness_next;
  logic [BW-1:0]      brightness_phase, brightness_phase_next;
  logic [1:0]         pwm_phase;
  logic [ADV_W-1:0]   advance_count, advance_count_next;
  logic [POS_W-1:0]   hour_index, hour_index_next;
  logic [POS_W-1:0]   minute_index, minute_index_next;

  // result register
  logic                 out_valid;
  logic [RING_LEDS-1:0] outer_leds, outer_leds_next;
  logic [RING_LEDS-1:0] inner_leds, inner_leds_next;
  logic [1:0]           mode_out;
  logic [POS_W-1:0]     hour_position, minute_position;

  logic       accept;
  btn_event_t events;

  logic [FLASH_W-1:0] flash_base, flash_inc;
  logic               flash_vis_base;
  logic [POS_W-1:0]   hour_edit, minute_edit;
  logic [BW:0]        bright_inc, bphase_inc;
  logic [ADV_W-1:0]   advance_inc;
  logic               hour_shown, minute_shown, lit;

  assign accept      = tick.valid && tick.ready;
  assign tick.ready  = !out_valid || result.ready;
  assign cfg.ready   = 1'b1;

  lrcc_button u_button (
    .clk              (clk),
    .rst              (rst),
    .tick             (accept),
    .pressed          (tick.button_pressed),
    .debounce_ticks   (debounce_ticks),
    .long_press_ticks (long_press_ticks),
    .events           (events)
  );

  // configuration writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks     <= DEBOUNCE_RESET;
      long_press_ticks   <= LONG_PRESS_RESET;
      blink_ticks        <= FLASH_RESET;
      ticks_per_advance  <= ADVANCE_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.reg_index)
        CFG_DEBOUNCE:   debounce_ticks     <= cfg.wdata[DEB_W-1:0];
        CFG_LONG_PRESS: long_press_ticks   <= cfg.wdata[LONG_W-1:0];
        CFG_FLASH:      blink_ticks        <= cfg.wdata[FLASH_W-1:0];
        CFG_ADVANCE:    ticks_per_advance  <= cfg.wdata[ADV_W-1:0];
        default: ;
      endcase
    end
  end

  // mode change, edits, flash, brightness phase, masks and clock advance
  always_comb begin
    mode_next      = events.long_press ? mode_t'(mode_reg + 2'd1) : mode_reg;
    flash_base     = events.long_press ? '0 : flash_count;
    flash_vis_base = events.long_press ? 1'b1 : flash_visible;

    // short press edit in the set modes
    hour_edit       = hour_index;
    minute_edit     = minute_index;
    brightness_next = brightness;
    bright_inc      = {1'b0, brightness} + (BW+1)'(1);
    if (events.short_press) begin
      case (mode_next)
        MODE_HOUR:   hour_edit   = (hour_index >= RING_LAST) ? '0 : hour_index + POS_W'(1);
        MODE_MINUTE: minute_edit = (minute_index >= RING_LAST) ? '0
                                                               : minute_index + POS_W'(1);
        MODE_BRIGHT: brightness_next = (bright_inc >= LEVELS_EXT) ? '0 : bright_inc[BW-1:0];
        default: ;
      endcase
    end

    // blink timer
    flash_inc = flash_base + FLASH_W'(1);
    if (flash_inc >= blink_ticks) begin
      flash_count_next   = '0;
      flash_visible_next = !flash_vis_base;
    end else begin
      flash_count_next   = flash_inc;
      flash_visible_next = flash_vis_base;
    end

    // brightness phase
    bphase_inc            = {1'b0, brightness_phase} + (BW+1)'(1);
    brightness_phase_next = (bphase_inc >= LEVELS_EXT) ? '0 : bphase_inc[BW-1:0];

    // blanking of the ring being edited
    hour_shown   = 1'b1;
    minute_shown = 1'b1;
    if (!flash_visible_next) begin
      case (mode_next)
        MODE_HOUR:   hour_shown = 1'b0;
        MODE_MINUTE: minute_shown = 1'b0;
        MODE_BRIGHT: begin
          hour_shown   = 1'b0;
          minute_shown = 1'b0;
        end
        default: ;
      endcase
    end

    lit             = (pwm_phase == 2'd0) && (brightness_phase_next <= brightness_next);
    outer_leds_next = (lit && hour_shown) ? RING_LEDS'(1) << hour_edit : '0;
    inner_leds_next = (lit && minute_shown) ? RING_LEDS'(1) << minute_edit : '0;

    // minute step in normal mode with carry into the hour ring
    hour_index_next    = hour_edit;
    minute_index_next  = minute_edit;
    advance_inc        = advance_count + ADV_W'(1);
    advance_count_next = '0;
    if (mode_next == MODE_RUN) begin
      if (advance_inc >= ticks_per_advance) begin
        if (minute_edit >= RING_LAST) begin
          minute_index_next = '0;
          hour_index_next   = (hour_edit >= RING_LAST) ? '0 : hour_edit + POS_W'(1);
        end else begin
          minute_index_next = minute_edit + POS_W'(1);
        end
      end else begin
        advance_count_next = advance_inc;
      end
    end
  end

  // state update per accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg         <= MODE_RUN;
      flash_count      <= '0;
      flash_visible    <= 1'b1;
      brightness       <= BRIGHT_TOP;
      brightness_phase <= '0;
      pwm_phase        <= 2'd0;
      advance_count    <= '0;
      hour_index       <= '0;
      minute_index     <= '0;
    end else if (accept) begin
      mode_reg         <= mode_next;
      flash_count      <= flash_count_next;
      flash_visible    <= flash_visible_next;
      brightness       <= brightness_next;
      brightness_phase <= brightness_phase_next;
      pwm_phase        <= pwm_phase + 2'd1;
      advance_count    <= advance_count_next;
      hour_index       <= hour_index_next;
      minute_index     <= minute_index_next;
    end
  end

  // result register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (accept) begin
      outer_leds      <= outer_leds_next;
      inner_leds      <= inner_leds_next;
      mode_out        <= mode_next;
      hour_position   <= hour_edit;
      minute_position <= minute_edit;
    end
  end

  assign result.valid           = out_valid;
  assign result.outer_leds      = outer_leds;
  assign result.inner_leds      = inner_leds;
  assign result.mode            = mode_out;
  assign result.hour_position   = hour_position;
  assign result.minute_position = minute_position;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// testbench: drives wakeup ticks and register writes into the led ring clock controller
// and checks every result against a tick-accurate model held in a scoreboard class
// depends on lrcc_pkg, the channel interfaces in lrcc_if and led_ring_clock_controller_unit

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lrcc_pkg::*;

  localparam int          LEVELS      = 8;
  localparam int          CLK_PERIOD  = 4;
  localparam int          RESET_TICKS = 11;
  localparam int          HOLD_CYCLES = 300;
  localparam int          CYCLE_LIMIT = 2_000_000;
  // an index past the end of the register file, writes there are dropped
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = '1;

  // one result as seen on the result channel
  typedef struct packed {
    logic [RING_LEDS-1:0] outer;
    logic [RING_LEDS-1:0] inner;
    mode_t                mode;
    logic [POS_W-1:0]     hour;
    logic [POS_W-1:0]     minute;
  } ring_face_t;

  // clock face model plus the queue of faces still to come out
  class ring_face_board;
    int unsigned      deb_limit, long_limit, flash_limit, step_limit;
    button_phase_t    phase;
    int unsigned      deb_cnt, press_cnt, flash_cnt, step_cnt;
    int unsigned      bright, bright_phase, pwm_cnt;
    bit               long_done, blink_lit;
    mode_t            mode;
    logic [POS_W-1:0] hour, minute;
    ring_face_t       faces_due[$];
    int               errors, checked, shorts, longs;
    bit [3:0]         modes_seen;

    function new();
      deb_limit    = DEBOUNCE_RESET;
      long_limit   = LONG_PRESS_RESET;
      flash_limit  = FLASH_RESET;
      step_limit   = ADVANCE_RESET;
      phase        = PH_IDLE;
      deb_cnt      = 0;
      press_cnt    = 0;
      flash_cnt    = 0;
      step_cnt     = 0;
      bright       = LEVELS - 1;
      bright_phase = 0;
      pwm_cnt      = 0;
      long_done    = 1'b0;
      blink_lit    = 1'b1;
      mode         = MODE_RUN;
      hour         = '0;
      minute       = '0;
      errors       = 0;
      checked      = 0;
      shorts       = 0;
      longs        = 0;
      modes_seen   = 4'b0001;
    endfunction

    function int pending();
      return faces_due.size();
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_DEBOUNCE:   deb_limit   = value[DEB_W-1:0];
        CFG_LONG_PRESS: long_limit  = value[LONG_W-1:0];
        CFG_FLASH:      flash_limit = value[FLASH_W-1:0];
        CFG_ADVANCE:    step_limit  = value[ADV_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [POS_W-1:0] ring_step(logic [POS_W-1:0] i);
      return (i >= RING_LAST) ? '0 : i + 1'b1;
    endfunction

    // debounce counter stops at its 16-bit top
    function void bump_debounce();
      if (deb_cnt < 16'hFFFF) deb_cnt++;
    endfunction

    // one accepted tick: update the clock and queue the face it shows
    function void note_tick(bit pressed);
      bit         short_ev, long_ev, hour_shown, minute_shown;
      ring_face_t face;
      short_ev     = 1'b0;
      long_ev      = 1'b0;
      hour_shown   = 1'b1;
      minute_shown = 1'b1;

      // button debouncer
      case (phase)
        PH_IDLE: begin
          if (pressed) begin
            phase   = PH_DEB_PRESS;
            deb_cnt = 1;
          end
        end
        PH_DEB_PRESS: begin
          if (pressed) begin
            bump_debounce();
            if (deb_cnt >= deb_limit) begin
              phase     = PH_PRESSED;
              press_cnt = 0;
              long_done = 1'b0;
            end
          end else begin
            phase   = PH_IDLE;
            deb_cnt = 0;
          end
        end
        PH_PRESSED: begin
          if (pressed) begin
            if (press_cnt < long_limit) press_cnt++;
            if (!long_done && press_cnt >= long_limit) begin
              long_ev   = 1'b1;
              long_done = 1'b1;
            end
          end else begin
            phase   = PH_DEB_RELEASE;
            deb_cnt = 1;
          end
        end
        default: begin
          if (!pressed) begin
            bump_debounce();
            if (deb_cnt >= deb_limit) begin
              // a hold that already gave a long press gives no short press
              if (!long_done) short_ev = 1'b1;
              phase   = PH_IDLE;
              deb_cnt = 0;
            end
          end else begin
            phase     = PH_PRESSED;
            press_cnt = 0;
            long_done = 1'b0;
          end
        end
      endcase

      // long press steps the mode and restarts the blink
      if (long_ev) begin
        mode      = mode_t'(mode + 2'd1);
        flash_cnt = 0;
        blink_lit = 1'b1;
        longs++;
        modes_seen[mode] = 1'b1;
      end

      // short press edits the selected item, ignored in normal mode
      if (short_ev) begin
        shorts++;
        case (mode)
          MODE_HOUR:   hour   = ring_step(hour);
          MODE_MINUTE: minute = ring_step(minute);
          MODE_BRIGHT: bright = (bright + 1 >= LEVELS) ? 0 : bright + 1;
          default: ;
        endcase
      end

      // blink and brightness counters
      flash_cnt++;
      if (flash_cnt >= flash_limit) begin
        flash_cnt = 0;
        blink_lit = !blink_lit;
      end
      bright_phase++;
      if (bright_phase >= LEVELS) bright_phase = 0;

      // blank the ring under edit while the blink is off
      if (!blink_lit) begin
        case (mode)
          MODE_HOUR:   hour_shown = 1'b0;
          MODE_MINUTE: minute_shown = 1'b0;
          MODE_BRIGHT: begin
            hour_shown   = 1'b0;
            minute_shown = 1'b0;
          end
          default: ;
        endcase
      end

      // ring masks from the current positions
      face.outer  = '0;
      face.inner  = '0;
      if (pwm_cnt == 0 && bright_phase <= bright) begin
        if (hour_shown) face.outer = RING_LEDS'(1) << hour;
        if (minute_shown) face.inner = RING_LEDS'(1) << minute;
      end
      face.mode   = mode;
      face.hour   = hour;
      face.minute = minute;
      faces_due.push_back(face);

      pwm_cnt = (pwm_cnt + 1) % 4;

      // time keeping runs only in normal mode
      if (mode == MODE_RUN) begin
        step_cnt++;
        if (step_cnt >= step_limit) begin
          step_cnt = 0;
          if (minute >= RING_LAST) begin
            minute = '0;
            hour   = ring_step(hour);
          end else begin
            minute = minute + 1'b1;
          end
        end
      end else begin
        step_cnt = 0;
      end
    endfunction

    // compare one accepted result with the oldest face due
    function void check_face(ring_face_t got);
      ring_face_t want;
      if (faces_due.size() == 0) begin
        $error("result with no tick waiting: outer_leds %h inner_leds %h",
               got.outer, got.inner);
        errors++;
        return;
      end
      want = faces_due.pop_front();
      checked++;
      if (got.outer !== want.outer) begin
        $error("outer_leds: expected %h, got %h", want.outer, got.outer);
        errors++;
      end
      if (got.inner !== want.inner) begin
        $error("inner_leds: expected %h, got %h", want.inner, got.inner);
        errors++;
      end
      if (got.mode !== want.mode) begin
        $error("mode: expected %0d, got %0d", want.mode, got.mode);
        errors++;
      end
      if (got.hour !== want.hour) begin
        $error("hour_position: expected %0d, got %0d", want.hour, got.hour);
        errors++;
      end
      if (got.minute !== want.minute) begin
        $error("minute_position: expected %0d, got %0d", want.minute, got.minute);
        errors++;
      end
    endfunction
  endclass

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  int             cycle_count = 0;
  int unsigned    ticks_sent = 0;
  bit             src_gaps = 1'b0;
  bit             sink_gaps = 1'b0;
  bit             hold_go = 1'b0;
  bit             hold_on = 1'b0;
  ring_face_t     seen;
  ring_face_board board = new();

  lrcc_tick_if   tick_ch ();
  lrcc_result_if res_ch ();
  lrcc_cfg_if    cfg_ch ();

  led_ring_clock_controller_unit #(
    .BRIGHTNESS_LEVELS(LEVELS)
  ) DUT (
    .clk   (clk),
    .rst   (rst),
    .tick  (tick_ch),
    .result(res_ch),
    .cfg   (cfg_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      seen.outer  = res_ch.outer_leds;
      seen.inner  = res_ch.inner_leds;
      seen.mode   = mode_t'(res_ch.mode);
      seen.hour   = res_ch.hour_position;
      seen.minute = res_ch.minute_position;
      board.check_face(seen);
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 92) return $urandom_range(3, 6);
    return $urandom_range(10, 40);
  endfunction

  // result receiver with random stalls
  initial begin : result_sink
    int unsigned stall_left;
    stall_left   = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_on) begin
        res_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        res_ch.ready <= 1'b0;
        stall_left--;
      end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
        stall_left = pick_gap() - 1;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // long receiver hold-off so that the output register fills and ticks back up
  initial begin : receiver_hold
    wait (hold_go);
    @(posedge clk);
    hold_on = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on = 1'b0;
  end

  task automatic send_tick(bit level);
    @(negedge clk);
    tick_ch.valid          <= 1'b1;
    tick_ch.button_pressed <= level;
    do @(posedge clk); while (!tick_ch.ready);
    board.note_tick(level);
    ticks_sent++;
  endtask

  task automatic idle_ticks(int unsigned n);
    repeat (n) begin
      @(negedge clk);
      tick_ch.valid          <= 1'b0;
      tick_ch.button_pressed <= 1'($urandom_range(0, 1));
    end
  endtask

  task automatic drive_level(bit level, int unsigned n);
    repeat (n) begin
      if (src_gaps && $urandom_range(0, 3) == 0) idle_ticks(pick_gap());
      send_tick(level);
    end
  endtask

  task automatic press(int unsigned hold_n, int unsigned release_n);
    drive_level(1'b1, hold_n);
    drive_level(1'b0, release_n);
  endtask

  // stop sending and wait until every face has come out
  task automatic settle();
    @(negedge clk);
    tick_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, int unsigned value);
    @(negedge clk);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wdata     <= CFG_DATA_W'(value);
    do @(posedge clk); while (!cfg_ch.ready);
    board.write_reg(idx, CFG_DATA_W'(value));
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic configure(int unsigned deb, int unsigned lng, int unsigned flash,
                           int unsigned adv);
    settle();
    write_reg(CFG_DEBOUNCE, deb);
    write_reg(CFG_LONG_PRESS, lng);
    write_reg(CFG_FLASH, flash);
    write_reg(CFG_ADVANCE, adv);
  endtask

  // one button gesture sized from the current thresholds
  task automatic gesture();
    int unsigned d, lp, r, k;
    d  = (board.deb_limit < 2) ? 2 : board.deb_limit;
    if (d > 40) d = 40;
    lp = (board.long_limit > 30) ? 30 : board.long_limit;
    if (!hold_on && $urandom_range(0, 19) == 0) src_gaps = !src_gaps;
    if (!hold_on && $urandom_range(0, 19) == 0) sink_gaps = !sink_gaps;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      press(d + lp + $urandom_range(1, 4), d + $urandom_range(0, 3));
    end else if (r < 70) begin
      // burst of short presses, long enough to wrap a ring
      k = $urandom_range(1, 14);
      repeat (k) press(d + ((lp > 0) ? $urandom_range(0, lp - 1) : 0),
                       d + $urandom_range(0, 3));
    end else if (r < 80) begin
      // hold well past the long press point when that is 30 or less, press counter saturates
      press(d + lp + $urandom_range(20, 60), d + $urandom_range(0, 3));
    end else if (r < 90) begin
      // contact bounce shorter than the debounce time, if that is 2 or more, inside a hold
      drive_level(1'b1, d + $urandom_range(0, lp));
      drive_level(1'b0, $urandom_range(1, d - 1));
      press(d + $urandom_range(0, lp), d + $urandom_range(0, 3));
    end else begin
      repeat ($urandom_range(1, 10)) drive_level(1'($urandom_range(0, 1)), 1);
    end
  endtask

  task automatic random_run(int unsigned count);
    int unsigned stop;
    stop = ticks_sent + count;
    while (ticks_sent < stop) gesture();
  endtask

  initial begin : stimulus
    tick_ch.valid          = 1'b0;
    tick_ch.button_pressed = 1'b0;
    cfg_ch.valid           = 1'b0;
    cfg_ch.reg_index       = '0;
    cfg_ch.wdata           = '0;
    repeat (RESET_TICKS) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset thresholds: a bounce that never gets through the debouncer
    drive_level(1'b0, 2);
    drive_level(1'b1, 3);
    drive_level(1'b0, 2);

    // short press in normal mode, long press into hour set, short press edits hour
    configure(1, 2, 3, 2);
    press(2, 2);
    press(5, 2);
    press(2, 2);

    // fast thresholds
    configure(1, 4, 2, 1);
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
    random_run(350);

    // receiver holds off while ticks keep coming
    configure(3, 8, 5, 3);
    random_run(150);
    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    hold_go   = 1'b1;
    random_run(150);
    wait (!hold_on);

    // zero thresholds
    configure(0, 0, 0, 0);
    random_run(250);

    // top thresholds for long press, blink and time step, plus a write off the end
    configure(2, 1048575, 65535, 16777215);
    write_reg(CFG_SPARE, 24'h5A5A5A);
    random_run(150);

    // top debounce threshold, a hold far shorter than it never registers
    configure(65535, 1, 40, 9);
    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    drive_level(1'b1, 30);
    drive_level(1'b0, 10);

    configure(2, 6, 7, 5);
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
    random_run(350);

    settle();
    $display("run covered %0d ticks and %0d results, %0d long and %0d short presses",
             ticks_sent, board.checked, board.longs, board.shorts);
    $display("modes reached %b, debounce, long press, blink and step limits from 0 to top",
             board.modes_seen);
    if (board.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
